// ===== rtl/d2q9_equilibrium_distribution_unit_assert.svh =====
// assertion macros used by the equilibrium unit checker
`ifndef D2Q9_EQUILIBRIUM_DISTRIBUTION_UNIT_ASSERT_SVH
`define D2Q9_EQUILIBRIUM_DISTRIBUTION_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is low
`define D2Q9EQ_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define D2Q9EQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/d2q9eq_pkg.sv =====
// shared constants and types of the d2q9 equilibrium unit
package d2q9eq_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_DIRS   = 9;
    localparam int IN_DATA_W  = 3 * WORD_W;
    localparam int OUT_DATA_W = NUM_DIRS * WORD_W;

    // population order in the result
    localparam int DIR_REST      = 0;
    localparam int DIR_EAST      = 1;
    localparam int DIR_NORTH     = 2;
    localparam int DIR_WEST      = 3;
    localparam int DIR_SOUTH     = 4;
    localparam int DIR_NORTHEAST = 5;
    localparam int DIR_NORTHWEST = 6;
    localparam int DIR_SOUTHWEST = 7;
    localparam int DIR_SOUTHEAST = 8;

    // internal widths
    localparam int M_W    = 48;  // density times weight, q16.32
    localparam int SQ_W   = 47;  // rounded square, q31.16
    localparam int POLY_W = 51;  // signed polynomial, q35.16
    localparam int PM_W   = 50;  // polynomial magnitude

    // pipeline split
    localparam int FRONT_STAGES = 3;
    localparam int POLY_STAGES  = 5;
    localparam int POP_STAGES   = 3;
    localparam int NUM_STAGES   = FRONT_STAGES + POLY_STAGES + POP_STAGES;
    localparam int FRONT_FIRST  = 0;
    localparam int POLY_FIRST   = FRONT_FIRST + FRONT_STAGES;
    localparam int POP_FIRST    = POLY_FIRST + POLY_STAGES;

    // weights as q0.32
    localparam logic [WORD_W-1:0] W_REST = 32'd1908874354;
    localparam logic [WORD_W-1:0] W_AXIS = 32'd477218588;
    localparam logic [WORD_W-1:0] W_DIAG = 32'd119304647;

    localparam logic [WORD_W-1:0] VSCALE_RESET = 32'h0100_0000;
    localparam logic [WORD_W-1:0] MAG_MAX      = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] MAG_NEG      = 32'h8000_0000;

    typedef logic [NUM_STAGES-1:0] t_stage_vec;

    typedef struct packed {
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic signed [WORD_W-1:0] d1;  // sat(a + b)
        logic signed [WORD_W-1:0] d2;  // sat(b - a)
        logic [M_W-1:0]           m_rest;
        logic [M_W-1:0]           m_axis;
        logic [M_W-1:0]           m_diag;
    } t_front_out;

    typedef struct packed {
        logic [NUM_DIRS-1:0][POLY_W-1:0] poly;
        logic [M_W-1:0]                  m_rest;
        logic [M_W-1:0]                  m_axis;
        logic [M_W-1:0]                  m_diag;
    } t_poly_out;

endpackage

// ===== rtl/d2q9eq_flow.sv =====
// valid bits and per-stage load chain of the pipeline
module d2q9eq_flow import d2q9eq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_stage_vec o_load
);

    t_stage_vec r_vld;
    t_stage_vec n_vld;
    t_stage_vec w_load;

    // a stage loads when it is empty or its content moves on
    assign w_load[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;

    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_load
        assign w_load[k] = !r_vld[k] || w_load[k+1];
    end

    assign n_vld[0] = w_load[0] ? i_in_valid : r_vld[0];

    for (genvar k = 1; k < NUM_STAGES; k++) begin : g_next
        assign n_vld[k] = w_load[k] ? r_vld[k-1] : r_vld[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_load[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_load      = w_load;

endmodule

// ===== rtl/d2q9eq_front.sv =====
// velocity scaling, density weighting and diagonal projections
module d2q9eq_front import d2q9eq_pkg::*; (
    input  logic                     i_clk,
    input  logic [FRONT_STAGES-1:0]  i_load,
    input  logic [WORD_W-1:0]        i_scale,
    input  logic [WORD_W-1:0]        i_density,
    input  logic signed [WORD_W-1:0] i_vel_x,
    input  logic signed [WORD_W-1:0] i_vel_y,
    output t_front_out               o_data
);

    localparam int P_W = 2 * WORD_W;

    function automatic logic [M_W-1:0] round_m(input logic [P_W-1:0] p);
        logic [M_W:0] s;
        s = {1'b0, p[P_W-1:16]} + (M_W+1)'(p[15]);
        return s[M_W-1:0];
    endfunction

    // q.40 to q16.16 with rounding, magnitude saturated, sign applied
    function automatic logic signed [WORD_W-1:0] to_lattice(input logic [P_W-1:0] p,
                                                           input logic neg);
        logic [P_W-24:0]    s;
        logic [WORD_W-1:0]  mag;
        s   = {1'b0, p[P_W-1:24]} + (P_W-23)'(p[23]);
        mag = (s > (P_W-23)'(MAG_MAX)) ? MAG_MAX : s[WORD_W-1:0];
        return neg ? $signed(32'(-mag)) : $signed(mag);
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sum(input logic signed [WORD_W:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -33'sd2147483647) begin
            r = 32'sh8000_0001;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    logic [WORD_W-1:0] w_mag_x;
    logic [WORD_W-1:0] w_mag_y;

    assign w_mag_x = i_vel_x[WORD_W-1] ? 32'(-i_vel_x) : 32'(i_vel_x);
    assign w_mag_y = i_vel_y[WORD_W-1] ? 32'(-i_vel_y) : 32'(i_vel_y);

    // stage 1: products
    logic [P_W-1:0] r_px;
    logic [P_W-1:0] r_py;
    logic           r_nx;
    logic           r_ny;
    logic [P_W-1:0] r_prho_rest;
    logic [P_W-1:0] r_prho_axis;
    logic [P_W-1:0] r_prho_diag;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_px        <= 64'(w_mag_x) * 64'(i_scale);
            r_py        <= 64'(w_mag_y) * 64'(i_scale);
            r_nx        <= i_vel_x[WORD_W-1];
            r_ny        <= i_vel_y[WORD_W-1];
            r_prho_rest <= 64'(i_density) * 64'(W_REST);
            r_prho_axis <= 64'(i_density) * 64'(W_AXIS);
            r_prho_diag <= 64'(i_density) * 64'(W_DIAG);
        end
    end

    // stage 2: rounding
    logic signed [WORD_W-1:0] r_a;
    logic signed [WORD_W-1:0] r_b;
    logic [M_W-1:0]           r_m_rest;
    logic [M_W-1:0]           r_m_axis;
    logic [M_W-1:0]           r_m_diag;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_a      <= to_lattice(r_px, r_nx);
            r_b      <= to_lattice(r_py, r_ny);
            r_m_rest <= round_m(r_prho_rest);
            r_m_axis <= round_m(r_prho_axis);
            r_m_diag <= round_m(r_prho_diag);
        end
    end

    // stage 3: diagonal projections
    t_front_out r_out;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_out.a      <= r_a;
            r_out.b      <= r_b;
            r_out.d1     <= sat_sum(33'(r_a) + 33'(r_b));
            r_out.d2     <= sat_sum(33'(r_b) - 33'(r_a));
            r_out.m_rest <= r_m_rest;
            r_out.m_axis <= r_m_axis;
            r_out.m_diag <= r_m_diag;
        end
    end

    assign o_data = r_out;

endmodule

// ===== rtl/d2q9eq_poly.sv =====
// squares, base term and the nine equilibrium polynomials
module d2q9eq_poly import d2q9eq_pkg::*; (
    input  logic                   i_clk,
    input  logic [POLY_STAGES-1:0] i_load,
    input  t_front_out             i_data,
    output t_poly_out              o_data
);

    localparam int NUM_CU = 4;
    localparam int CU_A   = 0;
    localparam int CU_B   = 1;
    localparam int CU_D1  = 2;
    localparam int CU_D2  = 3;
    localparam int SQP_W  = 2 * (WORD_W - 1);
    localparam int T3_W   = WORD_W + 2;
    localparam int Q9_W   = 50;
    localparam int S3_W   = 50;

    logic signed [WORD_W-1:0] w_cu  [NUM_CU];
    logic [WORD_W-2:0]        w_mag [NUM_CU];

    assign w_cu[CU_A]  = i_data.a;
    assign w_cu[CU_B]  = i_data.b;
    assign w_cu[CU_D1] = i_data.d1;
    assign w_cu[CU_D2] = i_data.d2;

    // projections are already saturated to 31-bit magnitudes
    for (genvar k = 0; k < NUM_CU; k++) begin : g_mag
        logic [WORD_W-1:0] w_abs;
        assign w_abs    = w_cu[k][WORD_W-1] ? 32'(-w_cu[k]) : 32'(w_cu[k]);
        assign w_mag[k] = w_abs[WORD_W-2:0];
    end

    // stage 4: raw squares
    logic [SQP_W-1:0]         r_s4_sqp [NUM_CU];
    logic signed [WORD_W-1:0] r_s4_cu  [NUM_CU];
    logic [M_W-1:0]           r_s4_m_rest;
    logic [M_W-1:0]           r_s4_m_axis;
    logic [M_W-1:0]           r_s4_m_diag;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            for (int k = 0; k < NUM_CU; k++) begin
                r_s4_sqp[k] <= SQP_W'(w_mag[k]) * SQP_W'(w_mag[k]);
                r_s4_cu[k]  <= w_cu[k];
            end
            r_s4_m_rest <= i_data.m_rest;
            r_s4_m_axis <= i_data.m_axis;
            r_s4_m_diag <= i_data.m_diag;
        end
    end

    // stage 5: rounded squares and 3*cu
    logic [SQ_W-1:0]        r_s5_sq [NUM_CU];
    logic signed [T3_W-1:0] r_s5_t3 [NUM_CU];
    logic [M_W-1:0]         r_s5_m_rest;
    logic [M_W-1:0]         r_s5_m_axis;
    logic [M_W-1:0]         r_s5_m_diag;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            for (int k = 0; k < NUM_CU; k++) begin
                r_s5_sq[k] <= {1'b0, r_s4_sqp[k][SQP_W-1:16]} + SQ_W'(r_s4_sqp[k][15]);
                r_s5_t3[k] <= (T3_W'(r_s4_cu[k]) <<< 1) + T3_W'(r_s4_cu[k]);
            end
            r_s5_m_rest <= r_s4_m_rest;
            r_s5_m_axis <= r_s4_m_axis;
            r_s5_m_diag <= r_s4_m_diag;
        end
    end

    // stage 6: 3*(sa + sb) and 9*sq
    logic [S3_W-1:0]        r_s6_s3;
    logic [Q9_W-1:0]        r_s6_q9 [NUM_CU];
    logic signed [T3_W-1:0] r_s6_t3 [NUM_CU];
    logic [M_W-1:0]         r_s6_m_rest;
    logic [M_W-1:0]         r_s6_m_axis;
    logic [M_W-1:0]         r_s6_m_diag;

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_s6_s3 <= (S3_W'(r_s5_sq[CU_A]) << 1) + S3_W'(r_s5_sq[CU_A])
                     + (S3_W'(r_s5_sq[CU_B]) << 1) + S3_W'(r_s5_sq[CU_B]);
            for (int k = 0; k < NUM_CU; k++) begin
                r_s6_q9[k] <= (Q9_W'(r_s5_sq[k]) << 3) + Q9_W'(r_s5_sq[k]);
                r_s6_t3[k] <= r_s5_t3[k];
            end
            r_s6_m_rest <= r_s5_m_rest;
            r_s6_m_axis <= r_s5_m_axis;
            r_s6_m_diag <= r_s5_m_diag;
        end
    end

    // stage 7: base and rounded halves
    logic [S3_W-1:0]          w_half_s3;
    logic signed [POLY_W-1:0] r_s7_base;
    logic [Q9_W-1:0]          r_s7_h  [NUM_CU];
    logic signed [T3_W-1:0]   r_s7_t3 [NUM_CU];
    logic [M_W-1:0]           r_s7_m_rest;
    logic [M_W-1:0]           r_s7_m_axis;
    logic [M_W-1:0]           r_s7_m_diag;

    assign w_half_s3 = S3_W'(r_s6_s3[S3_W-1:1]) + S3_W'(r_s6_s3[0]);

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_s7_base <= POLY_W'(65536) - POLY_W'(w_half_s3);
            for (int k = 0; k < NUM_CU; k++) begin
                r_s7_h[k]  <= Q9_W'(r_s6_q9[k][Q9_W-1:1]) + Q9_W'(r_s6_q9[k][0]);
                r_s7_t3[k] <= r_s6_t3[k];
            end
            r_s7_m_rest <= r_s6_m_rest;
            r_s7_m_axis <= r_s6_m_axis;
            r_s7_m_diag <= r_s6_m_diag;
        end
    end

    // stage 8: polynomials, arithmetic taken modulo 2^POLY_W
    logic [POLY_W-1:0] w_t3 [NUM_CU];
    logic [POLY_W-1:0] w_h  [NUM_CU];

    for (genvar k = 0; k < NUM_CU; k++) begin : g_ext
        assign w_t3[k] = POLY_W'(r_s7_t3[k]);
        assign w_h[k]  = POLY_W'(r_s7_h[k]);
    end

    t_poly_out r_out;

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r_out.poly[DIR_REST]      <= r_s7_base;
            r_out.poly[DIR_EAST]      <= r_s7_base + w_t3[CU_A] + w_h[CU_A];
            r_out.poly[DIR_NORTH]     <= r_s7_base + w_t3[CU_B] + w_h[CU_B];
            r_out.poly[DIR_WEST]      <= r_s7_base - w_t3[CU_A] + w_h[CU_A];
            r_out.poly[DIR_SOUTH]     <= r_s7_base - w_t3[CU_B] + w_h[CU_B];
            r_out.poly[DIR_NORTHEAST] <= r_s7_base + w_t3[CU_D1] + w_h[CU_D1];
            r_out.poly[DIR_NORTHWEST] <= r_s7_base + w_t3[CU_D2] + w_h[CU_D2];
            r_out.poly[DIR_SOUTHWEST] <= r_s7_base - w_t3[CU_D1] + w_h[CU_D1];
            r_out.poly[DIR_SOUTHEAST] <= r_s7_base - w_t3[CU_D2] + w_h[CU_D2];
            r_out.m_rest              <= r_s7_m_rest;
            r_out.m_axis              <= r_s7_m_axis;
            r_out.m_diag              <= r_s7_m_diag;
        end
    end

    assign o_data = r_out;

endmodule

// ===== rtl/d2q9eq_popmul.sv =====
// one population: split product of weight term and polynomial, round, saturate
module d2q9eq_popmul import d2q9eq_pkg::*; (
    input  logic                  i_clk,
    input  logic [POP_STAGES-1:0] i_load,
    input  logic [POLY_W-1:0]     i_poly,
    input  logic [M_W-1:0]        i_m,
    output logic [WORD_W-1:0]     o_pop
);

    localparam int PL_W   = 25;
    localparam int PH_W   = PM_W - PL_W;
    localparam int ML_W   = 24;
    localparam int MH_W   = M_W - ML_W;
    localparam int PP_W   = 49;
    localparam int PROD_W = PM_W + M_W;
    localparam int R_W    = PROD_W - WORD_W + 1;

    logic              w_neg;
    logic [POLY_W-1:0] w_abs;
    logic [PM_W-1:0]   w_pm;

    assign w_neg = i_poly[POLY_W-1];
    assign w_abs = w_neg ? POLY_W'(-i_poly) : i_poly;
    assign w_pm  = w_abs[PM_W-1:0];

    // stage 9: partial products
    logic [PP_W-1:0] r_pp_ll;
    logic [PP_W-1:0] r_pp_lh;
    logic [PP_W-1:0] r_pp_hl;
    logic [PP_W-1:0] r_pp_hh;
    logic            r_neg9;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_pp_ll <= PP_W'(w_pm[PL_W-1:0])     * PP_W'(i_m[ML_W-1:0]);
            r_pp_lh <= PP_W'(w_pm[PL_W-1:0])     * PP_W'(i_m[ML_W +: MH_W]);
            r_pp_hl <= PP_W'(w_pm[PL_W +: PH_W]) * PP_W'(i_m[ML_W-1:0]);
            r_pp_hh <= PP_W'(w_pm[PL_W +: PH_W]) * PP_W'(i_m[ML_W +: MH_W]);
            r_neg9  <= w_neg;
        end
    end

    // stage 10: full product
    logic [PROD_W-1:0] r_prod;
    logic              r_neg10;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_prod  <= (PROD_W'(r_pp_hh) << (PL_W + ML_W))
                     + (PROD_W'(r_pp_hl) << PL_W)
                     + (PROD_W'(r_pp_lh) << ML_W)
                     + PROD_W'(r_pp_ll);
            r_neg10 <= r_neg9;
        end
    end

    // stage 11: q16.16 with rounding and saturation; overflow lands in saturation too
    logic [R_W-1:0]    w_r;
    logic [WORD_W-1:0] w_mag;
    logic [WORD_W-1:0] r_pop;

    assign w_r = {1'b0, r_prod[PROD_W-1:WORD_W]} + R_W'(r_prod[WORD_W-1]);

    always_comb begin
        if (r_neg10) begin
            w_mag = (w_r > R_W'(MAG_NEG)) ? MAG_NEG : w_r[WORD_W-1:0];
        end else begin
            w_mag = (w_r > R_W'(MAG_MAX)) ? MAG_MAX : w_r[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_pop <= r_neg10 ? WORD_W'(-w_mag) : w_mag;
        end
    end

    assign o_pop = r_pop;

endmodule

// ===== rtl/d2q9_equilibrium_distribution_unit.sv =====
// top level of the d2q9 lattice boltzmann equilibrium unit
//
//  channel  | direction | width | contents (low bits first)
//  ---------+-----------+-------+---------------------------------------------
//  s_axis   | in        | 96    | density, vel_x, vel_y
//  m_axis   | out       | 288   | rest, east, north, west, south,
//           |           |       | northeast, northwest, southwest, southeast
//  cfg      | in        | 32    | velocity_scale, q8.24
//
// one cell accepted per clock; 11 register stages from input transfer to result,
// set by the multiplier chain (scale, square, 4-way split population product)
// velocity_scale resets to 1.0; the pipeline comes out of reset empty
// each stage loads when empty or when its content moves on, so bubbles close up
// and input keeps flowing on a stalled output until all 11 stages are full
module d2q9_equilibrium_distribution_unit import d2q9eq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // density, vel_x, vel_y
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // pop_rest, pop_east, pop_north,
                                                    // pop_west, pop_south, pop_northeast,
                                                    // pop_northwest, pop_southwest,
                                                    // pop_southeast
    input  logic                  i_cfg_we,
    input  logic [WORD_W-1:0]     i_cfg_wdata
);

    logic [WORD_W-1:0] r_velocity_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_velocity_scale <= VSCALE_RESET;
        end else if (i_cfg_we) begin
            r_velocity_scale <= i_cfg_wdata;
        end
    end

    t_stage_vec w_load;
    t_front_out w_front;
    t_poly_out  w_poly;

    d2q9eq_flow u_flow (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_load      (w_load)
    );

    d2q9eq_front u_front (
        .i_clk     (i_clk),
        .i_load    (w_load[FRONT_FIRST +: FRONT_STAGES]),
        .i_scale   (r_velocity_scale),
        .i_density (i_s_axis_tdata[0 +: WORD_W]),
        .i_vel_x   ($signed(i_s_axis_tdata[WORD_W +: WORD_W])),
        .i_vel_y   ($signed(i_s_axis_tdata[2*WORD_W +: WORD_W])),
        .o_data    (w_front)
    );

    d2q9eq_poly u_poly (
        .i_clk  (i_clk),
        .i_load (w_load[POLY_FIRST +: POLY_STAGES]),
        .i_data (w_front),
        .o_data (w_poly)
    );

    for (genvar g = 0; g < NUM_DIRS; g++) begin : g_pop
        logic [M_W-1:0] w_m;

        if (g == DIR_REST) begin : g_rest
            assign w_m = w_poly.m_rest;
        end else if (g <= DIR_SOUTH) begin : g_axis
            assign w_m = w_poly.m_axis;
        end else begin : g_diag
            assign w_m = w_poly.m_diag;
        end

        d2q9eq_popmul u_popmul (
            .i_clk  (i_clk),
            .i_load (w_load[POP_FIRST +: POP_STAGES]),
            .i_poly (w_poly.poly[g]),
            .i_m    (w_m),
            .o_pop  (o_m_axis_tdata[g*WORD_W +: WORD_W])
        );
    end

endmodule

// ===== rtl/d2q9eq_checker.sv =====
// port-level checks of the equilibrium unit and their binding
module d2q9eq_checker import d2q9eq_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

`include "d2q9_equilibrium_distribution_unit_assert.svh"

    // a waiting result holds until its transfer
    `D2Q9EQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // an empty output stage means the pipeline can take a cell
    `D2Q9EQ_ASSERT_IMPLY(a_empty_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input stalled with empty output")

    // a draining output lets the whole pipeline advance
    `D2Q9EQ_ASSERT_IMPLY(a_drain_ready, i_clk, i_rst_n, i_m_axis_tready, o_s_axis_tready, "input stalled while output drains")

endmodule

bind d2q9_equilibrium_distribution_unit d2q9eq_checker u_d2q9eq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
